/* rtl/sega_pkg.sv */
// Package with the item types, cell codes and widths of the grid automaton.
`timescale 1ns / 1ps
package sega_pkg;

    localparam int unsigned CLASS_W = 2;
    localparam int unsigned AGE_W   = 8;
    localparam int unsigned TALLY_W = 15;
    localparam int unsigned THR_W   = 17;
    localparam int unsigned COORD_W = 7;
    localparam logic [TALLY_W-1:0] TALLY_MAX = 15'd32767;

    localparam logic [1:0] CLS_HEALTHY  = 2'd0;
    localparam logic [1:0] CLS_INFECTED = 2'd1;
    localparam logic [1:0] CLS_CURED    = 2'd2;
    localparam logic [1:0] CLS_DEAD     = 2'd3;

    localparam logic [1:0] CMD_INIT = 2'd0;
    localparam logic [1:0] CMD_STEP = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;
    localparam logic [1:0] CMD_NOP  = 2'd3;

    localparam logic [2:0] REG_GRID_DIM  = 3'd0;
    localparam logic [2:0] REG_LETHALITY = 3'd1;
    localparam logic [2:0] REG_INFECT    = 3'd2;
    localparam logic [2:0] REG_CURE      = 3'd3;
    localparam logic [2:0] REG_MAX_AGE   = 3'd4;
    localparam logic [2:0] REG_SEED      = 3'd5;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [COORD_W-1:0] cell_row;
        logic [COORD_W-1:0] cell_col;
    } t_in_item;

    typedef struct packed {
        logic [CLASS_W-1:0] cell_class;
        logic [AGE_W-1:0]   infection_age;
        logic [TALLY_W-1:0] healthy_count;
        logic [TALLY_W-1:0] infected_count;
        logic [TALLY_W-1:0] cured_count;
        logic [TALLY_W-1:0] dead_count;
        logic               status;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_pos;     // restart the scan at row 0, column 0
        logic adv_pos;     // move the scan to the next cell
        logic clr_tally;   // zero the tallies
        logic fetch;       // read neighborhood of the current cell
        logic wr_clear;    // write a healthy cell at the scan position
        logic wr_seed;     // write the infected center cell
        logic wr_next;     // write the next generation cell, draw numbers
        logic count;       // read current bank at scan position
        logic count_add;   // add the class read to the tallies
        logic flip_bank;   // swap banks
        logic load_rng;    // load the generator from the seed
        logic rd_cell;     // read the cell for a read item
        logic emit;        // present the result
    } t_ctl;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_pos;    // scan position is the last cell of the grid
    } t_sts;

endpackage

/* rtl/sega_datapath.sv */
// Datapath of the grid automaton: cell memory, generator, tallies and results.
`timescale 1ns / 1ps
module sega_datapath #(
    parameter int unsigned GRID_MAX  = 128,
    parameter int unsigned PROB_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sega_pkg::t_ctl        i_ctl,
    output sega_pkg::t_sts        o_sts,
    input  sega_pkg::t_in_item    i_item,
    input  logic [7:0]            i_grid_dim,
    input  logic [sega_pkg::THR_W-1:0] i_leth_thr,
    input  logic [sega_pkg::THR_W-1:0] i_inf_thr,
    input  logic [sega_pkg::THR_W-1:0] i_cure_thr,
    input  logic [7:0]            i_max_age,
    input  logic [31:0]           i_seed,
    output logic                  o_result_valid,
    output sega_pkg::t_out_item   o_result
);
    localparam int unsigned POS_W  = $clog2(GRID_MAX);
    localparam int unsigned DIM_W  = $clog2(GRID_MAX + 1);
    localparam int unsigned ADDR_W = 2 * POS_W + 1;
    localparam int unsigned CELL_W = sega_pkg::CLASS_W + sega_pkg::AGE_W;

    // Grid size in use, clamped to 1..GRID_MAX.
    logic [DIM_W-1:0] w_dim;
    always_comb begin
        if (i_grid_dim == 8'd0) begin
            w_dim = DIM_W'(1);
        end else if (32'(i_grid_dim) > GRID_MAX) begin
            w_dim = DIM_W'(GRID_MAX);
        end else begin
            w_dim = DIM_W'(i_grid_dim);
        end
    end
    logic [7:0] w_lim;
    assign w_lim = (i_max_age == 8'd0) ? 8'd1 : i_max_age;

    // Scan position.
    logic [POS_W-1:0] r_row, r_col;
    logic [POS_W-1:0] w_last;
    assign w_last = POS_W'(w_dim - DIM_W'(1));
    assign o_sts.last_pos = (r_row == w_last) && (r_col == w_last);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (i_ctl.clr_pos) begin
            r_row <= '0;
            r_col <= '0;
        end else if (i_ctl.adv_pos) begin
            if (r_col == w_last) begin
                r_col <= '0;
                r_row <= r_row + POS_W'(1);
            end else begin
                r_col <= r_col + POS_W'(1);
            end
        end
    end

    logic r_bank;

    // One cell memory holding both banks, with one read port and one write
    // port; the center and neighbors of a cell are fetched one after another.
    logic [CELL_W-1:0] r_mem [0:(1 << ADDR_W)-1];
    logic [CELL_W-1:0] r_rd;
    logic [2:0]  r_fcnt;
    logic [3:0]  r_nbr;
    logic [CELL_W-1:0] r_center;

    function automatic logic [ADDR_W-1:0] f_addr(input logic b, input logic [POS_W-1:0] r,
                                                 input logic [POS_W-1:0] c);
        f_addr = {b, r, c};
    endfunction

    // Neighbor sequencing: fetch count 0 center, 1 up, 2 down, 3 left, 4 right.
    logic [ADDR_W-1:0] w_raddr;
    logic              w_nbr_ok;
    logic [POS_W-1:0]  w_half;
    assign w_half = POS_W'(w_dim >> 1);
    always_comb begin
        w_raddr  = f_addr(r_bank, r_row, r_col);
        w_nbr_ok = 1'b1;
        if (i_ctl.rd_cell) begin
            w_raddr = f_addr(r_bank, POS_W'(i_item.cell_row), POS_W'(i_item.cell_col));
        end else if (i_ctl.fetch) begin
            case (r_fcnt)
                3'd1: begin
                    w_raddr  = f_addr(r_bank, r_row - POS_W'(1), r_col);
                    w_nbr_ok = (r_row != '0);
                end
                3'd2: begin
                    w_raddr  = f_addr(r_bank, r_row + POS_W'(1), r_col);
                    w_nbr_ok = (r_row != w_last);
                end
                3'd3: begin
                    w_raddr  = f_addr(r_bank, r_row, r_col - POS_W'(1));
                    w_nbr_ok = (r_col != '0);
                end
                3'd4: begin
                    w_raddr  = f_addr(r_bank, r_row, r_col + POS_W'(1));
                    w_nbr_ok = (r_col != w_last);
                end
                default: w_nbr_ok = 1'b1;
            endcase
        end
    end

    // Generator and next-cell logic.
    logic [31:0] r_rng;
    function automatic logic [31:0] f_xs(input logic [31:0] x);
        logic [31:0] y;
        y = x ^ (x << 13);
        y = y ^ (y >> 17);
        y = y ^ (y << 5);
        f_xs = y;
    endfunction
    logic [31:0] w_x1, w_x2;
    assign w_x1 = f_xs(r_rng);
    assign w_x2 = f_xs(w_x1);
    logic w_p1_leth, w_p1_inf, w_p2_cure;
    assign w_p1_leth = 32'(w_x1 >> (32 - PROB_BITS)) < 32'(i_leth_thr);
    assign w_p1_inf  = 32'(w_x1 >> (32 - PROB_BITS)) < 32'(i_inf_thr);
    assign w_p2_cure = 32'(w_x2 >> (32 - PROB_BITS)) < 32'(i_cure_thr);

    logic [CELL_W-1:0] w_next;
    logic [1:0]        w_draws;
    logic [1:0]        w_cls;
    logic [8:0]        w_age1;
    assign w_cls  = r_center[CELL_W-1 -: 2];
    assign w_age1 = {1'b0, r_center[7:0]} + 9'd1;
    always_comb begin
        w_next  = r_center;
        w_draws = 2'd0;
        case (w_cls)
            sega_pkg::CLS_INFECTED: begin
                w_draws = 2'd1;
                if (w_p1_leth) begin
                    w_next = {sega_pkg::CLS_DEAD, 8'd0};
                end else if (w_age1 > {1'b0, w_lim}) begin
                    w_draws = 2'd2;
                    w_next  = w_p2_cure ? {sega_pkg::CLS_CURED, 8'd0}
                                        : {sega_pkg::CLS_INFECTED, w_lim};
                end else begin
                    w_next = {sega_pkg::CLS_INFECTED, w_age1[7:0]};
                end
            end
            sega_pkg::CLS_HEALTHY: begin
                w_next = '0;
                if (r_nbr != 4'd0) begin
                    w_draws = 2'd1;
                    if (w_p1_inf) w_next = {sega_pkg::CLS_INFECTED, 8'd1};
                end
            end
            default: w_next = r_center;
        endcase
    end

    // Memory write port.
    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    logic [CELL_W-1:0] w_wdata;
    always_comb begin
        w_we    = i_ctl.wr_clear | i_ctl.wr_seed | i_ctl.wr_next;
        w_waddr = f_addr(r_bank, r_row, r_col);
        w_wdata = '0;
        if (i_ctl.wr_seed) begin
            w_waddr = f_addr(r_bank, w_half, w_half);
            w_wdata = {sega_pkg::CLS_INFECTED, 8'd1};
        end else if (i_ctl.wr_next) begin
            w_waddr = f_addr(~r_bank, r_row, r_col);
            w_wdata = w_next;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
        r_rd <= r_mem[w_raddr];
    end

    // Fetch bookkeeping: the registered read data arrives in the cycle after its address.
    logic r_fetch_d;
    logic [2:0] r_fcnt_d;
    logic r_ok_d;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fcnt    <= '0;
            r_fetch_d <= 1'b0;
        end else begin
            r_fetch_d <= i_ctl.fetch;
            if (i_ctl.fetch) begin
                r_fcnt <= (r_fcnt == 3'd4) ? 3'd0 : r_fcnt + 3'd1;
            end
        end
        r_fcnt_d <= r_fcnt;
        r_ok_d   <= w_nbr_ok;
        if (r_fetch_d) begin
            if (r_fcnt_d == 3'd0) begin
                r_center <= r_rd;
                r_nbr    <= '0;
            end else begin
                r_nbr[r_fcnt_d[1:0]] <= r_ok_d && (r_rd[CELL_W-1 -: 2] ==
                                                     sega_pkg::CLS_INFECTED);
            end
        end
    end

    // Generator state and bank select.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rng  <= 32'd1;
            r_bank <= 1'b0;
        end else begin
            if (i_ctl.load_rng) begin
                r_rng <= (i_seed == 32'd0) ? 32'd1 : i_seed;
            end else if (i_ctl.wr_next) begin
                if (w_draws == 2'd1) r_rng <= w_x1;
                else if (w_draws == 2'd2) r_rng <= w_x2;
            end
            if (i_ctl.flip_bank) r_bank <= ~r_bank;
        end
    end

    // Tallies.
    logic [sega_pkg::TALLY_W-1:0] r_t [0:3];
    logic r_count_d;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count_d <= 1'b0;
            for (int i = 0; i < 4; i++) r_t[i] <= '0;
        end else begin
            r_count_d <= i_ctl.count;
            if (i_ctl.clr_tally) begin
                for (int i = 0; i < 4; i++) r_t[i] <= '0;
            end else if (i_ctl.count_add && r_count_d) begin
                if (r_t[r_rd[CELL_W-1 -: 2]] != sega_pkg::TALLY_MAX) begin
                    r_t[r_rd[CELL_W-1 -: 2]] <= r_t[r_rd[CELL_W-1 -: 2]] + 15'd1;
                end
            end
        end
    end

    // Result register.
    logic r_rd_pend, r_out_of_grid;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_result_valid <= 1'b0;
            r_rd_pend      <= 1'b0;
        end else begin
            o_result_valid <= i_ctl.emit;
            r_rd_pend      <= i_ctl.rd_cell;
        end
        if (i_ctl.rd_cell) begin
            r_out_of_grid <= (32'(i_item.cell_row) >= 32'(w_dim)) ||
                             (32'(i_item.cell_col) >= 32'(w_dim));
        end
        if (i_ctl.emit) begin
            o_result.healthy_count  <= r_t[0];
            o_result.infected_count <= r_t[1];
            o_result.cured_count    <= r_t[2];
            o_result.dead_count     <= r_t[3];
            o_result.cell_class     <= sega_pkg::CLS_HEALTHY;
            o_result.infection_age  <= '0;
            o_result.status         <= 1'b0;
            if (r_rd_pend) begin
                if (r_out_of_grid) begin
                    o_result.status <= 1'b1;
                end else begin
                    o_result.cell_class <= r_rd[CELL_W-1 -: 2];
                    if (r_rd[CELL_W-1 -: 2] == sega_pkg::CLS_INFECTED) begin
                        o_result.infection_age <= r_rd[7:0];
                    end
                end
            end
        end
    end
endmodule

/* rtl/sega_ctrl.sv */
// Controller state machine of the grid automaton.
`timescale 1ns / 1ps
module sega_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [1:0]         i_cmd,
    output logic               o_busy,
    output sega_pkg::t_ctl     o_ctl,
    input  sega_pkg::t_sts     i_sts
);
    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_CLEAR  = 9'b000000010,
        S_SEED   = 9'b000000100,
        S_FETCH  = 9'b000001000,
        S_WAIT   = 9'b000010000,
        S_WRITE  = 9'b000100000,
        S_COUNT  = 9'b001000000,
        S_DRAIN  = 9'b010000000,
        S_EMIT   = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic [2:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_ctl   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_ctl.clr_pos = 1'b1;
                    case (i_cmd)
                        sega_pkg::CMD_INIT: begin
                            o_ctl.load_rng = 1'b1;
                            n_state = S_CLEAR;
                        end
                        sega_pkg::CMD_STEP: begin
                            n_cnt   = '0;
                            n_state = S_FETCH;
                        end
                        sega_pkg::CMD_READ: begin
                            o_ctl.rd_cell = 1'b1;
                            n_state = S_EMIT;
                        end
                        default: n_state = S_EMIT;
                    endcase
                end
            end
            S_CLEAR: begin
                o_ctl.wr_clear = 1'b1;
                o_ctl.adv_pos  = 1'b1;
                if (i_sts.last_pos) n_state = S_SEED;
            end
            S_SEED: begin
                o_ctl.wr_seed   = 1'b1;
                o_ctl.clr_pos   = 1'b1;
                o_ctl.clr_tally = 1'b1;
                n_state = S_COUNT;
            end
            // Five reads: center and four neighbors.
            S_FETCH: begin
                o_ctl.fetch = 1'b1;
                n_cnt = r_cnt + 3'd1;
                if (r_cnt == 3'd4) n_state = S_WAIT;
            end
            S_WAIT: n_state = S_WRITE;
            S_WRITE: begin
                o_ctl.wr_next = 1'b1;
                n_cnt = '0;
                if (i_sts.last_pos) begin
                    o_ctl.flip_bank = 1'b1;
                    o_ctl.clr_pos   = 1'b1;
                    o_ctl.clr_tally = 1'b1;
                    n_state = S_COUNT;
                end else begin
                    o_ctl.adv_pos = 1'b1;
                    n_state = S_FETCH;
                end
            end
            // Tally pass over the current bank, one read per cycle.
            S_COUNT: begin
                o_ctl.count     = 1'b1;
                o_ctl.count_add = 1'b1;
                o_ctl.adv_pos   = 1'b1;
                if (i_sts.last_pos) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                o_ctl.count_add = 1'b1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                o_ctl.emit = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

/* rtl/stochastic_epidemic_grid_automaton.sv */
// Top level of the stochastic epidemic grid automaton.
`timescale 1ns / 1ps
// Usage: an item (cmd, cell_row, cell_col) is taken when start is high and
// busy is low. Each item yields one result on o_result, marked by
// o_result_valid for one cycle; the receiver must take it then.
// Registers are written through i_cfg_valid/o_cfg_ready with an index and
// data; write them only while the block is idle.
// Sequence of work, with N the grid side in use:
//   read or no operation: only the result step.
//   init: a clear pass over the N*N cells, the seed write and a tally pass.
//   step: for each cell five reads of the one memory read port, a wait
//   and a write, then a tally pass over the N*N cells.
// The single read port of the cell memory sets this sequence.
// Reset loads the register defaults, bank 0, generator state 1 and zero
// tallies; cell contents are undefined until the first init.
// The receiver cannot stall.
module stochastic_epidemic_grid_automaton #(
    parameter int unsigned GRID_MAX  = 128,
    parameter int unsigned PROB_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  sega_pkg::t_in_item  i_item,
    output logic                o_result_valid,
    output sega_pkg::t_out_item o_result,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data
);
    logic [7:0]  r_grid_dim, r_max_age;
    logic [16:0] r_leth, r_inf, r_cure;
    logic [31:0] r_seed;

    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_dim <= 8'd100;
            r_leth     <= 17'd655;
            r_inf      <= 17'd6554;
            r_cure     <= 17'd65536;
            r_max_age  <= 8'd10;
            r_seed     <= 32'd1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                sega_pkg::REG_GRID_DIM:  r_grid_dim <= i_cfg_data[7:0];
                sega_pkg::REG_LETHALITY: r_leth     <= i_cfg_data[16:0];
                sega_pkg::REG_INFECT:    r_inf      <= i_cfg_data[16:0];
                sega_pkg::REG_CURE:      r_cure     <= i_cfg_data[16:0];
                sega_pkg::REG_MAX_AGE:   r_max_age  <= i_cfg_data[7:0];
                sega_pkg::REG_SEED:      r_seed     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    sega_pkg::t_ctl w_ctl;
    sega_pkg::t_sts w_sts;

    sega_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_cmd   (i_item.cmd),
        .o_busy  (busy),
        .o_ctl   (w_ctl),
        .i_sts   (w_sts)
    );

    sega_datapath #(
        .GRID_MAX  (GRID_MAX),
        .PROB_BITS (PROB_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (w_ctl),
        .o_sts          (w_sts),
        .i_item         (i_item),
        .i_grid_dim     (r_grid_dim),
        .i_leth_thr     (r_leth),
        .i_inf_thr      (r_inf),
        .i_cure_thr     (r_cure),
        .i_max_age      (r_max_age),
        .i_seed         (r_seed),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );
endmodule

/* verif/tb_stochastic_epidemic_grid_automaton.sv */
// Self-checking testbench for the stochastic epidemic grid automaton.
`timescale 1ns / 1ps
module tb_stochastic_epidemic_grid_automaton;

    localparam int unsigned SIDE_MAX   = 128;
    localparam int unsigned BANK_SIZE  = SIDE_MAX * SIDE_MAX;
    localparam int unsigned CYCLE_LIMIT = 3000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    sega_pkg::t_in_item  i_item;
    logic        o_result_valid;
    sega_pkg::t_out_item o_result;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    stochastic_epidemic_grid_automaton i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // Shadow copy of the registers and the grid state.
    logic [7:0]  dim_reg;
    logic [16:0] lethal_thr;
    logic [16:0] infect_thr;
    logic [16:0] cure_thr;
    logic [7:0]  age_limit;
    logic [31:0] seed_reg;
    logic [9:0]  grid_mem [0:2*BANK_SIZE-1];
    logic        cur_bank;
    logic [31:0] rng;
    logic [sega_pkg::TALLY_W-1:0] tally [0:3];
    // Side of the square region of each bank that holds written cells.
    int unsigned written_side [0:1];

    sega_pkg::t_out_item expected_results [$];
    int          error_count;
    int          cfg_acks;
    int          cycle_count;
    int          max_gap;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned side_in_use();
        if (dim_reg == 8'd0) return 1;
        if (dim_reg > SIDE_MAX) return SIDE_MAX;
        return dim_reg;
    endfunction

    function automatic int unsigned cell_addr(input logic bank, input int unsigned r,
                                              input int unsigned c);
        return bank * BANK_SIZE + r * SIDE_MAX + c;
    endfunction

    // One xorshift32 advance; the draw is the top 16 bits of the new state.
    function automatic bit draw_passes(input logic [16:0] thr);
        logic [31:0] x;
        x = rng;
        x = x ^ (x << 13);
        x = x ^ (x >> 17);
        x = x ^ (x << 5);
        rng = x;
        return {1'b0, x[31:16]} < thr;
    endfunction

    function automatic bit is_infected(input int unsigned r, input int unsigned c);
        return grid_mem[cell_addr(cur_bank, r, c)][9:8] == sega_pkg::CLS_INFECTED;
    endfunction

    function automatic logic [9:0] next_generation(input int unsigned r, input int unsigned c,
                                                   input int unsigned n);
        logic [9:0] v;
        int unsigned age;
        int unsigned lim;
        v = grid_mem[cell_addr(cur_bank, r, c)];
        lim = (age_limit == 8'd0) ? 1 : age_limit;
        if (v[9:8] == sega_pkg::CLS_CURED || v[9:8] == sega_pkg::CLS_DEAD) return v;
        if (v[9:8] == sega_pkg::CLS_INFECTED) begin
            if (draw_passes(lethal_thr)) return {sega_pkg::CLS_DEAD, 8'd0};
            age = v[7:0] + 1;
            if (age > lim) begin
                if (draw_passes(cure_thr)) return {sega_pkg::CLS_CURED, 8'd0};
                age = lim;
            end
            return {sega_pkg::CLS_INFECTED, age[7:0]};
        end
        if ((r > 0 && is_infected(r - 1, c)) || (r + 1 < n && is_infected(r + 1, c)) ||
            (c > 0 && is_infected(r, c - 1)) || (c + 1 < n && is_infected(r, c + 1))) begin
            if (draw_passes(infect_thr)) return {sega_pkg::CLS_INFECTED, 8'd1};
        end
        return 10'd0;
    endfunction

    function automatic void recount_tallies();
        int unsigned n;
        logic [1:0] k;
        n = side_in_use();
        for (int i = 0; i < 4; i++) tally[i] = '0;
        for (int unsigned r = 0; r < n; r++)
            for (int unsigned c = 0; c < n; c++) begin
                k = grid_mem[cell_addr(cur_bank, r, c)][9:8];
                if (tally[k] < sega_pkg::TALLY_MAX) tally[k] = tally[k] + 1'b1;
            end
    endfunction

    // Work out the result of one accepted item and update the shadow state.
    function automatic sega_pkg::t_out_item predict_epidemic(input sega_pkg::t_in_item it);
        sega_pkg::t_out_item res;
        int unsigned n;
        logic other;
        logic [9:0] v;
        n = side_in_use();
        res = '0;
        case (it.cmd)
            sega_pkg::CMD_INIT: begin
                for (int unsigned r = 0; r < n; r++)
                    for (int unsigned c = 0; c < n; c++)
                        grid_mem[cell_addr(cur_bank, r, c)] = 10'd0;
                grid_mem[cell_addr(cur_bank, n / 2, n / 2)] = {sega_pkg::CLS_INFECTED, 8'd1};
                rng = (seed_reg == 32'd0) ? 32'd1 : seed_reg;
                if (written_side[cur_bank] < n) written_side[cur_bank] = n;
                recount_tallies();
            end
            sega_pkg::CMD_STEP: begin
                other = ~cur_bank;
                for (int unsigned r = 0; r < n; r++)
                    for (int unsigned c = 0; c < n; c++)
                        grid_mem[cell_addr(other, r, c)] = next_generation(r, c, n);
                if (written_side[other] < n) written_side[other] = n;
                cur_bank = other;
                recount_tallies();
            end
            sega_pkg::CMD_READ: begin
                if (it.cell_row >= n || it.cell_col >= n) begin
                    res.status = 1'b1;
                end else begin
                    v = grid_mem[cell_addr(cur_bank, it.cell_row, it.cell_col)];
                    res.cell_class = v[9:8];
                    res.infection_age = (v[9:8] == sega_pkg::CLS_INFECTED) ? v[7:0] : 8'd0;
                end
            end
            default: ;
        endcase
        res.healthy_count  = tally[0];
        res.infected_count = tally[1];
        res.cured_count    = tally[2];
        res.dead_count     = tally[3];
        return res;
    endfunction

    // Send one item; the block is sampled idle at a falling edge, so the item
    // is taken at the next rising edge.
    task automatic send_item(input logic [1:0] cmd, input int unsigned row,
                             input int unsigned col);
        sega_pkg::t_in_item it;
        repeat ($urandom_range(max_gap, 0)) @(negedge i_clk);
        while (busy) @(negedge i_clk);
        it.cmd = cmd;
        it.cell_row = row[sega_pkg::COORD_W-1:0];
        it.cell_col = col[sega_pkg::COORD_W-1:0];
        i_item = it;
        start = 1'b1;
        expected_results.push_back(predict_epidemic(it));
        @(negedge i_clk);
        start = 1'b0;
    endtask

    // Before a step or read of a bank that no init has written, an init is sent first.
    task automatic send_safe(input logic [1:0] cmd, input int unsigned row,
                             input int unsigned col);
        if ((cmd == sega_pkg::CMD_STEP || cmd == sega_pkg::CMD_READ) &&
            written_side[cur_bank] < side_in_use())
            send_item(sega_pkg::CMD_INIT, 0, 0);
        send_item(cmd, row, col);
    endtask

    task automatic wait_idle();
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        while (busy) @(negedge i_clk);
    endtask

    // Register write; the shadow registers follow the masking of the block.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        int acks;
        acks = cfg_acks;
        i_cfg_index = idx;
        i_cfg_data = data;
        i_cfg_valid = 1'b1;
        while (cfg_acks == acks) @(negedge i_clk);
        i_cfg_valid = 1'b0;
        case (idx)
            sega_pkg::REG_GRID_DIM:  dim_reg = data[7:0];
            sega_pkg::REG_LETHALITY: lethal_thr = data[16:0];
            sega_pkg::REG_INFECT:    infect_thr = data[16:0];
            sega_pkg::REG_CURE:      cure_thr = data[16:0];
            sega_pkg::REG_MAX_AGE:   age_limit = data[7:0];
            sega_pkg::REG_SEED:      seed_reg = data;
            default: ;
        endcase
    endtask

    task automatic set_all_regs(input logic [31:0] dim, input logic [31:0] leth,
                                input logic [31:0] inf, input logic [31:0] cure,
                                input logic [31:0] age, input logic [31:0] seed);
        write_reg(sega_pkg::REG_GRID_DIM, dim);
        write_reg(sega_pkg::REG_LETHALITY, leth);
        write_reg(sega_pkg::REG_INFECT, inf);
        write_reg(sega_pkg::REG_CURE, cure);
        write_reg(sega_pkg::REG_MAX_AGE, age);
        write_reg(sega_pkg::REG_SEED, seed);
    endtask

    // Count configuration handshakes and check each result against the oldest prediction.
    always @(posedge i_clk) begin
        sega_pkg::t_out_item exp_res;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
        if (i_rst_n && i_cfg_valid && o_cfg_ready) cfg_acks++;
        if (i_rst_n && o_result_valid) begin
            if (expected_results.size() == 0) begin
                $error("result with no item outstanding");
                error_count++;
            end else begin
                exp_res = expected_results.pop_front();
                if (o_result.cell_class !== exp_res.cell_class) begin
                    $error("cell_class expected %0d actual %0d",
                           exp_res.cell_class, o_result.cell_class);
                    error_count++;
                end
                if (o_result.infection_age !== exp_res.infection_age) begin
                    $error("infection_age expected %0d actual %0d",
                           exp_res.infection_age, o_result.infection_age);
                    error_count++;
                end
                if (o_result.healthy_count !== exp_res.healthy_count) begin
                    $error("healthy_count expected %0d actual %0d",
                           exp_res.healthy_count, o_result.healthy_count);
                    error_count++;
                end
                if (o_result.infected_count !== exp_res.infected_count) begin
                    $error("infected_count expected %0d actual %0d",
                           exp_res.infected_count, o_result.infected_count);
                    error_count++;
                end
                if (o_result.cured_count !== exp_res.cured_count) begin
                    $error("cured_count expected %0d actual %0d",
                           exp_res.cured_count, o_result.cured_count);
                    error_count++;
                end
                if (o_result.dead_count !== exp_res.dead_count) begin
                    $error("dead_count expected %0d actual %0d",
                           exp_res.dead_count, o_result.dead_count);
                    error_count++;
                end
                if (o_result.status !== exp_res.status) begin
                    $error("status expected %0d actual %0d", exp_res.status, o_result.status);
                    error_count++;
                end
            end
        end
    end

    // Reset values: a default-sized grid, one generation and the border reads.
    task automatic test_reset_defaults();
        max_gap = 3;
        send_item(sega_pkg::CMD_NOP, 0, 0);
        send_item(sega_pkg::CMD_INIT, 0, 0);
        send_item(sega_pkg::CMD_READ, 50, 50);
        send_item(sega_pkg::CMD_READ, 99, 99);
        send_item(sega_pkg::CMD_READ, 100, 0);
        send_item(sega_pkg::CMD_READ, 0, 127);
        send_item(sega_pkg::CMD_STEP, 0, 0);
        send_item(sega_pkg::CMD_READ, 49, 50);
        send_item(sega_pkg::CMD_NOP, 127, 127);
        wait_idle();
    endtask

    // Extreme thresholds: certain death, certain infection, no cure, zero age limit.
    task automatic test_threshold_extremes();
        set_all_regs(32'd5, 32'd65536, 32'd65536, 32'd0, 32'd0, 32'd0);
        max_gap = 0;
        send_item(sega_pkg::CMD_INIT, 0, 0);
        send_item(sega_pkg::CMD_STEP, 0, 0);
        send_item(sega_pkg::CMD_READ, 2, 2);
        wait_idle();
        write_reg(sega_pkg::REG_LETHALITY, 32'd0);
        send_item(sega_pkg::CMD_INIT, 0, 0);
        repeat (3) send_item(sega_pkg::CMD_STEP, 0, 0);
        send_item(sega_pkg::CMD_READ, 2, 2);
        send_item(sega_pkg::CMD_READ, 2, 3);
        wait_idle();
        write_reg(sega_pkg::REG_CURE, 32'd65536);
        send_item(sega_pkg::CMD_STEP, 0, 0);
        send_item(sega_pkg::CMD_READ, 2, 2);
        send_item(sega_pkg::CMD_READ, 4, 4);
        send_item(sega_pkg::CMD_READ, 5, 4);
        wait_idle();
    endtask

    // Grid side zero and one, masked register bits and unused register indexes.
    task automatic test_tiny_grid_and_masking();
        max_gap = 10;
        set_all_regs(32'hFFFF_FF00, 32'hFFFE_0000, 32'h0003_0000, 32'hFFFF_FFFF,
                     32'h0000_01FF, 32'hFFFF_FFFF);
        write_reg(3'd6, 32'h0000_0001);
        write_reg(3'd7, 32'hFFFF_FFFF);
        send_item(sega_pkg::CMD_INIT, 0, 0);
        send_item(sega_pkg::CMD_STEP, 0, 0);
        send_item(sega_pkg::CMD_READ, 0, 0);
        send_item(sega_pkg::CMD_READ, 0, 1);
        wait_idle();
        write_reg(sega_pkg::REG_GRID_DIM, 32'd1);
        send_item(sega_pkg::CMD_STEP, 0, 0);
        send_item(sega_pkg::CMD_READ, 0, 0);
        wait_idle();
    endtask

    // Largest grid: a side above the maximum acts as the maximum.
    task automatic test_largest_grid();
        max_gap = 2;
        set_all_regs(32'd255, 32'd655, 32'd30000, 32'd20000, 32'd255, 32'hDEAD_BEEF);
        send_item(sega_pkg::CMD_INIT, 0, 0);
        send_item(sega_pkg::CMD_STEP, 0, 0);
        send_item(sega_pkg::CMD_READ, 64, 64);
        send_item(sega_pkg::CMD_READ, 63, 64);
        send_item(sega_pkg::CMD_READ, 127, 127);
        wait_idle();
    endtask

    function automatic logic [31:0] random_threshold();
        case ($urandom_range(5, 0))
            0: return 32'd0;
            1: return 32'd65536;
            2: return $urandom();
            default: return $urandom_range(65535, 0);
        endcase
    endfunction

    // Random phases of small grids with random settings and mixed commands.
    task automatic test_random_phases();
        int unsigned n;
        int unsigned pick;
        logic [31:0] dim;
        for (int phase = 0; phase < 4; phase++) begin
            dim = ($urandom_range(7, 0) == 0) ? $urandom() : $urandom_range(9, 0);
            if (dim[7:0] > 12) dim[7:0] = $urandom_range(12, 1);
            set_all_regs(dim, random_threshold(), random_threshold(), random_threshold(),
                         ($urandom_range(3, 0) == 0) ? $urandom() : $urandom_range(6, 0),
                         $urandom());
            max_gap = (phase % 3 == 0) ? 0 : 10;
            send_item(sega_pkg::CMD_INIT, 0, 0);
            n = side_in_use();
            for (int k = 0; k < 17; k++) begin
                pick = $urandom_range(19, 0);
                if (pick < 2) send_safe(sega_pkg::CMD_INIT, 0, 0);
                else if (pick < 9) send_safe(sega_pkg::CMD_STEP, $urandom_range(127, 0),
                                             $urandom_range(127, 0));
                else if (pick < 11) send_safe(sega_pkg::CMD_NOP, $urandom_range(127, 0),
                                              $urandom_range(127, 0));
                else if (pick < 14) send_safe(sega_pkg::CMD_READ, $urandom_range(127, 0),
                                              $urandom_range(127, 0));
                else send_safe(sega_pkg::CMD_READ, $urandom_range(n - 1, 0),
                               $urandom_range(n - 1, 0));
            end
            wait_idle();
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_item = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = sega_pkg::REG_GRID_DIM;
        i_cfg_data = '0;
        error_count = 0;
        cfg_acks = 0;
        cycle_count = 0;
        max_gap = 0;
        dim_reg = 8'd100;
        lethal_thr = 17'd655;
        infect_thr = 17'd6554;
        cure_thr = 17'd65536;
        age_limit = 8'd10;
        seed_reg = 32'd1;
        for (int i = 0; i < 2 * BANK_SIZE; i++) grid_mem[i] = 10'd0;
        cur_bank = 1'b0;
        rng = 32'd1;
        for (int i = 0; i < 4; i++) tally[i] = '0;
        written_side[0] = 0;
        written_side[1] = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_reset_defaults();
        test_threshold_extremes();
        test_tiny_grid_and_masking();
        test_largest_grid();
        test_random_phases();

        wait_idle();
        repeat (20) @(negedge i_clk);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
